>>> src/fxq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fxq_pkg;
  localparam int FracBits = 8;
  localparam int WordBits = 32;
  localparam int NumBits  = WordBits + FracBits;

  typedef logic [3:0] op_t;
  localparam op_t OpAdd = 4'd0;
  localparam op_t OpSub = 4'd1;
  localparam op_t OpMul = 4'd2;
  localparam op_t OpDiv = 4'd3;
  localparam op_t OpFromInt = 4'd4;
  localparam op_t OpToInt = 4'd5;
  localparam op_t OpInc = 4'd6;
  localparam op_t OpDec = 4'd7;
  localparam op_t OpMin = 4'd8;
  localparam op_t OpMax = 4'd9;
  localparam op_t OpCmp = 4'd10;

  typedef struct packed {
    logic is_less;
    logic is_equal;
    logic is_greater;
  } flags_t;

  // Sideband that travels beside the divider.
  typedef struct packed {
    op_t                        op;
    logic signed [WordBits-1:0] simple;
    flags_t                     flags;
    logic                       dz;
    logic                       neg;
  } side_t;
endpackage
`default_nettype wire

>>> src/fixed_point_q24_8_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | signals                                          | beat
// in      | in_valid/in_ready, op, operand_a, operand_b      | one operation
// out     | out_valid/out_ready, result_value, four flags    | one result
//
// Pipeline: a decode and multiply register, 40 restoring-divide steps,
// then finish logic into the output register.
// Throughput: one beat per cycle while the output is not stalled; the 40-step divider sets the depth.
// Reset clears the valid bits only; payload registers are not reset.
// Stall: when the output holds an unaccepted beat the whole pipe freezes,
// so nothing is lost or repeated.
module fixed_point_q24_8_alu import fxq_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [3:0]                 op,
  input  wire logic signed [WordBits-1:0] operand_a,
  input  wire logic signed [WordBits-1:0] operand_b,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [WordBits-1:0]      result_value,
  output logic                            is_less,
  output logic                            is_equal,
  output logic                            is_greater,
  output logic                            divide_by_zero
);
  logic en;
  flags_t flags;

  // Advance whenever the output slot is empty or being drained.
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  fxq_pipe u_pipe (
    .clk(clk), .rst(rst), .en(en), .in_v(in_valid && en),
    .op(op), .operand_a(operand_a), .operand_b(operand_b),
    .out_v(out_valid), .out_value(result_value), .out_flags(flags),
    .out_dz(divide_by_zero)
  );

  assign is_less = flags.is_less;
  assign is_equal = flags.is_equal;
  assign is_greater = flags.is_greater;
endmodule
`default_nettype wire

>>> src/fxq_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// One restoring-division step on the magnitudes: shift in one dividend bit.
module fxq_div_stage import fxq_pkg::*; (
  input  wire logic [NumBits-1:0]  num_in,
  input  wire logic [WordBits:0]   rem_in,
  input  wire logic [WordBits-1:0] den,
  output logic      [NumBits-1:0]  num_out,
  output logic      [WordBits:0]   rem_out
);
  logic [WordBits+1:0] trial;
  always_comb begin
    trial = {rem_in, num_in[NumBits-1]};
    if (trial >= {2'b00, den}) begin
      trial = trial - {2'b00, den};
      num_out = {num_in[NumBits-2:0], 1'b1};
    end else begin
      num_out = {num_in[NumBits-2:0], 1'b0};
    end
    rem_out = trial[WordBits:0];
  end
endmodule
`default_nettype wire

>>> src/fxq_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: decode and multiply, NumBits divide stages, finish into the output register.
module fxq_pipe import fxq_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_v,
  input  wire op_t                        op,
  input  wire logic signed [WordBits-1:0] operand_a,
  input  wire logic signed [WordBits-1:0] operand_b,
  output logic                            out_v,
  output logic signed [WordBits-1:0]      out_value,
  output flags_t                          out_flags,
  output logic                            out_dz
);
  localparam int Depth = NumBits;

  // decode stage
  logic v0;
  side_t s0;
  logic signed [2*WordBits-1:0] prod0;
  logic [NumBits-1:0] num0;
  logic [WordBits-1:0] den0;
  side_t s0_next;
  logic [WordBits-1:0] ma, mb;

  always_comb begin
    s0_next.op = op;
    s0_next.flags.is_less = operand_a < operand_b;
    s0_next.flags.is_equal = operand_a == operand_b;
    s0_next.flags.is_greater = operand_a > operand_b;
    s0_next.dz = (op == OpDiv) && (operand_b == '0);
    s0_next.neg = operand_a[WordBits-1] ^ operand_b[WordBits-1];
    case (op)
      OpAdd: s0_next.simple = operand_a + operand_b;
      OpSub: s0_next.simple = operand_a - operand_b;
      OpFromInt: s0_next.simple = operand_a <<< FracBits;
      OpToInt: s0_next.simple = operand_a >>> FracBits;
      OpInc: s0_next.simple = operand_a + WordBits'(1);
      OpDec: s0_next.simple = operand_a - WordBits'(1);
      OpMin: s0_next.simple = (operand_a < operand_b) ? operand_a : operand_b;
      OpMax: s0_next.simple = (operand_a > operand_b) ? operand_a : operand_b;
      default: s0_next.simple = '0;
    endcase
    ma = operand_a[WordBits-1] ? (~operand_a + 1'b1) : operand_a;
    mb = operand_b[WordBits-1] ? (~operand_b + 1'b1) : operand_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_v;
    end
    if (en) begin
      s0 <= s0_next;
      prod0 <= (2*WordBits)'(operand_a) * (2*WordBits)'(operand_b);
      num0 <= {ma, {FracBits{1'b0}}};
      den0 <= mb;
    end
  end

  // divide stages; the product rides along
  logic                 v [Depth+1];
  side_t                s [Depth+1];
  logic [NumBits-1:0]   num [Depth+1];
  logic [WordBits:0]    rem [Depth+1];
  logic [WordBits-1:0]  den [Depth+1];
  logic [WordBits-1:0]  mulr [Depth+1];

  assign v[0] = v0;
  assign s[0] = s0;
  assign num[0] = num0;
  assign rem[0] = '0;
  assign den[0] = den0;
  assign mulr[0] = prod0[FracBits +: WordBits];

  for (genvar i = 0; i < Depth; i++) begin : g_div
    logic [NumBits-1:0] num_c;
    logic [WordBits:0] rem_c;
    fxq_div_stage u_stage (
      .num_in(num[i]), .rem_in(rem[i]), .den(den[i]),
      .num_out(num_c), .rem_out(rem_c)
    );
    logic vr;
    side_t sr;
    logic [NumBits-1:0] nr;
    logic [WordBits:0] rr;
    logic [WordBits-1:0] dr, mr;
    always_ff @(posedge clk) begin
      if (rst) begin
        vr <= 1'b0;
      end else if (en) begin
        vr <= v[i];
      end
      if (en) begin
        sr <= s[i];
        nr <= num_c;
        rr <= rem_c;
        dr <= den[i];
        mr <= mulr[i];
      end
    end
    assign v[i+1] = vr;
    assign s[i+1] = sr;
    assign num[i+1] = nr;
    assign rem[i+1] = rr;
    assign den[i+1] = dr;
    assign mulr[i+1] = mr;
  end

  // finish stage
  logic [WordBits-1:0] q;
  logic signed [WordBits-1:0] value_next;
  side_t sl;
  always_comb begin
    sl = s[Depth];
    q = num[Depth][WordBits-1:0];
    case (sl.op)
      OpMul: value_next = mulr[Depth];
      OpDiv: value_next = sl.dz ? '0 : (sl.neg ? (~q + 1'b1) : q);
      default: value_next = sl.simple;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= v[Depth];
    end
    if (en) begin
      out_value <= value_next;
      out_flags <= sl.flags;
      out_dz <= sl.dz;
    end
  end
endmodule
`default_nettype wire

>>> src/fxq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module fxq_checker import fxq_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic is_less,
  input wire logic is_equal,
  input wire logic is_greater,
  input wire logic signed [WordBits-1:0] result_value,
  input wire logic divide_by_zero
);
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({is_less, is_equal, is_greater}))
    else $error("compare flags not one-hot");
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result_value == '0)
    else $error("divide by zero gave nonzero value");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during stall");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value))
    else $error("stalled result changed");
endmodule

bind fixed_point_q24_8_alu fxq_checker u_fxq_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .is_less(is_less), .is_equal(is_equal),
  .is_greater(is_greater), .result_value(result_value),
  .divide_by_zero(divide_by_zero)
);
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import fxq_pkg::*;

  typedef struct packed {
    logic signed [WordBits-1:0] value;
    logic                       lt;
    logic                       eq;
    logic                       gt;
    logic                       dz;
  } alu_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [3:0]                 op = OpAdd;
  logic signed [WordBits-1:0] operand_a = '0;
  logic signed [WordBits-1:0] operand_b = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [WordBits-1:0] result_value;
  logic                       is_less;
  logic                       is_equal;
  logic                       is_greater;
  logic                       divide_by_zero;

  alu_result_t expected_results[$];
  int          error_count = 0;
  int          beats_sent = 0;
  int          beats_checked = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  fixed_point_q24_8_alu dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .is_less(is_less), .is_equal(is_equal),
    .is_greater(is_greater), .divide_by_zero(divide_by_zero)
  );

  always #6 clk = ~clk;

  // Predict one ALU result from the operation and raw operands.
  function automatic alu_result_t alu_predict(logic [3:0] code,
                                              logic signed [WordBits-1:0] a,
                                              logic signed [WordBits-1:0] b);
    alu_result_t r;
    logic signed [2*WordBits-1:0] prod;
    logic signed [2*WordBits-1:0] num;
    logic signed [2*WordBits-1:0] quo;
    r = '0;
    r.lt = a < b;
    r.eq = a == b;
    r.gt = a > b;
    case (code)
      OpAdd: r.value = a + b;
      OpSub: r.value = a - b;
      OpMul: begin
        prod = 64'(a) * 64'(b);
        r.value = WordBits'(prod >>> FracBits);
      end
      OpDiv: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          // SV signed division truncates toward zero; the 64-bit width
          // holds the widened dividend, only the quotient is wrapped.
          num = 64'(a) <<< FracBits;
          quo = num / 64'(b);
          r.value = WordBits'(quo);
        end
      end
      OpFromInt: r.value = a <<< FracBits;
      OpToInt: r.value = a >>> FracBits;
      OpInc: r.value = a + 1;
      OpDec: r.value = a - 1;
      OpMin: r.value = r.lt ? a : b;
      OpMax: r.value = r.gt ? a : b;
      default: r.value = '0;
    endcase
    return r;
  endfunction

  // Send one beat, holding valid and payload until accepted. Valid drops
  // only while the sender idles, so back-to-back beats keep it high.
  task automatic send_beat(logic [3:0] code, logic signed [WordBits-1:0] a,
                           logic signed [WordBits-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= code;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(alu_predict(code, a, b));
    beats_sent++;
  endtask

  // Receiver: randomly stall, compare each accepted beat with the oldest
  // expectation.
  always @(posedge clk) begin
    alu_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: value %0d", result_value);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          beats_checked++;
          if (result_value !== want.value) begin
            $error("result_value expected %0d actual %0d", want.value, result_value);
            error_count++;
          end
          if (is_less !== want.lt) begin
            $error("is_less expected %0b actual %0b", want.lt, is_less);
            error_count++;
          end
          if (is_equal !== want.eq) begin
            $error("is_equal expected %0b actual %0b", want.eq, is_equal);
            error_count++;
          end
          if (is_greater !== want.gt) begin
            $error("is_greater expected %0b actual %0b", want.gt, is_greater);
            error_count++;
          end
          if (divide_by_zero !== want.dz) begin
            $error("divide_by_zero expected %0b actual %0b", want.dz, divide_by_zero);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [WordBits-1:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'sh7fffffff - $urandom_range(3);
      1: return 32'sh80000000 + $urandom_range(3);
      2: return $signed($urandom_range(2048)) - 1024;
      3: return $signed(($urandom_range(200) - 100) << FracBits);
      default: return $signed($urandom());
    endcase
  endfunction

  // Extremes of the operands under every op code, including unused ones.
  task automatic test_directed();
    logic signed [WordBits-1:0] edges[5];
    edges = '{32'sh80000000, 32'sh7fffffff, 0, -1, 32'sh100};
    for (int c = 0; c < 16; c++) begin
      send_beat(4'(c), edges[c % 5], edges[(c + 2) % 5]);
    end
    // Divide by zero, divide overflow, equal min/max, compare equal, min squared, to-int of -1.
    send_beat(OpDiv, 32'sh12345, 0);
    send_beat(OpDiv, 32'sh80000000, -1);
    send_beat(OpDiv, 32'sh7fffffff, 1);
    send_beat(OpMin, 777, 777);
    send_beat(OpMax, -5, -5);
    send_beat(OpCmp, 42, 42);
    send_beat(OpMul, 32'sh80000000, 32'sh80000000);
    send_beat(OpToInt, -1, 0);
  endtask

  task automatic test_random(int count);
    logic [3:0] code;
    for (int i = 0; i < count; i++) begin
      code = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11))
                                       : 4'($urandom_range(10));
      send_beat(code, pick_operand(),
                ($urandom_range(15) == 0) ? 32'sd0 : pick_operand());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 23;
    recv_idle_pct = 88;
    test_directed();
    test_random(200);
    send_idle_pct = 88;
    recv_idle_pct = 23;
    test_random(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250);
    drain();
    $display("covered %0d beats sent, %0d results checked", beats_sent, beats_checked);
    $display("all op codes incl. unused, operand extremes, divide by zero, idle mixes");
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end
endmodule

>>> sim.f
src/fxq_pkg.sv
src/fxq_div_stage.sv
src/fxq_pipe.sv
src/fixed_point_q24_8_alu.sv
src/fxq_checker.sv
dv/testbench.sv
